// ===== sv/range_distinct_count_window_assert.svh =====
`ifndef RANGE_DISTINCT_COUNT_WINDOW_ASSERT_SVH
`define RANGE_DISTINCT_COUNT_WINDOW_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled while in reset.
`define RDCW_ASSERT_IMPL(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("range_distinct_count_window: assertion failed");

// Next-cycle implication, sampled on i_clk and disabled while in reset.
`define RDCW_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("range_distinct_count_window: assertion failed");

`endif

// ===== sv/rdcw_pkg.sv =====
package rdcw_pkg;

    localparam int ELEMENT_SLOTS = 1024;
    localparam int VALUE_SLOTS   = 1024;

    localparam int EA_W   = $clog2(ELEMENT_SLOTS);
    localparam int VA_W   = $clog2(VALUE_SLOTS);
    localparam int EDGE_W = EA_W + 1;

    localparam int CMD_W = 2;
    localparam int IDX_W = 10;
    localparam int VAL_W = 10;
    localparam int TAG_W = 10;
    localparam int CNT_W = 11;
    localparam int OCC_W = 12;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_BAD   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // For a load, idx_a is the position and idx_b the value;
    // for a query they are the left and right ends of the range.
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic [TAG_W-1:0] tag;
    } t_entry;

endpackage

// ===== sv/rdcw_front.sv =====
module rdcw_front
    import rdcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CMD_W-1:0] i_command,
    input  logic [IDX_W-1:0] i_position,
    input  logic [VAL_W-1:0] i_value,
    input  logic [IDX_W-1:0] i_left,
    input  logic [IDX_W-1:0] i_right,
    input  logic [TAG_W-1:0] i_tag,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_init_done,
    output logic             o_push_valid,
    output t_entry           o_push_entry,
    input  logic             i_push_ready
);

    logic [CNT_W-1:0] r_element_count;
    logic             accept;
    logic             bad_range;
    logic             load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= '0;
        end else if (i_cfg_valid) begin
            r_element_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = i_push_ready && i_init_done;
    assign accept      = i_valid && o_ready;

    assign bad_range = (i_left > i_right)
                    || ({1'b0, i_right} >= r_element_count)
                    || (int'(i_right) >= ELEMENT_SLOTS);
    assign load_ok   = (int'(i_position) < ELEMENT_SLOTS) && (int'(i_value) < VALUE_SLOTS);

    always_comb begin
        o_push_valid       = 1'b0;
        o_push_entry.op    = OP_LOAD;
        o_push_entry.idx_a = i_left;
        o_push_entry.idx_b = i_right;
        o_push_entry.tag   = i_tag;
        unique case (i_command)
            CMD_LOAD: begin
                o_push_entry.op    = OP_LOAD;
                o_push_entry.idx_a = i_position;
                o_push_entry.idx_b = i_value;
                o_push_valid       = accept && load_ok;
            end
            CMD_QUERY: begin
                o_push_entry.op = bad_range ? OP_BAD : OP_QUERY;
                o_push_valid    = accept;
            end
            CMD_CLEAR: begin
                o_push_entry.op = OP_CLEAR;
                o_push_valid    = accept;
            end
            default: begin
                o_push_valid = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/rdcw_queue.sv =====
module rdcw_queue
    import rdcw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    input  t_entry i_push_entry,
    output logic   o_push_ready,
    output logic   o_pop_valid,
    output t_entry o_pop_entry,
    input  logic   i_pop_ready
);

    t_entry            r_slot [QUEUE_DEPTH];
    logic [QP_W-1:0]   r_wr_ptr;
    logic [QP_W-1:0]   r_rd_ptr;
    logic [QC_W-1:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QC_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QP_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QP_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QC_W'(1);
                2'b01:   r_count <= r_count - QC_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/rdcw_back.sv =====
module rdcw_back
    import rdcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop_valid,
    input  t_entry           i_pop_entry,
    output logic             o_pop_ready,
    output logic             o_init_done,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CNT_W-1:0] o_distinct_count,
    output logic [TAG_W-1:0] o_answer_tag,
    output logic             o_status
);

    typedef enum logic [5:0] {
        S_WIPE = 6'b000001,
        S_IDLE = 6'b000010,
        S_MOVE = 6'b000100,
        S_RDE  = 6'b001000,
        S_UPD  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state            r_state;
    logic              r_init_done;
    logic [VA_W-1:0]   r_wipe_addr;
    logic [EDGE_W-1:0] r_win_left;
    logic [EDGE_W-1:0] r_win_end;
    logic [CNT_W-1:0]  r_running;
    logic [EDGE_W-1:0] r_left;
    logic [EDGE_W-1:0] r_stop;
    logic [TAG_W-1:0]  r_tag;
    logic              r_add;
    logic              r_o_valid;
    logic [CNT_W-1:0]  r_o_count;
    logic [TAG_W-1:0]  r_o_tag;
    logic              r_o_status;

    logic [VAL_W-1:0]  r_elements [ELEMENT_SLOTS];
    logic [VAL_W-1:0]  r_elem_q;
    logic [OCC_W-1:0]  r_occ [VALUE_SLOTS];
    logic [OCC_W-1:0]  r_occ_q;
    logic [VA_W-1:0]   r_vaddr;

    logic              out_free;
    logic              out_load;
    logic              take;
    logic              load_take;
    logic              mv_left_up;
    logic              mv_left_dn;
    logic              mv_end_up;
    logic              mv_end_dn;
    logic              move_any;
    logic              mv_add;
    logic [EDGE_W-1:0] mv_addr;
    logic [EDGE_W-1:0] n_win_left;
    logic [EDGE_W-1:0] n_win_end;
    logic [OCC_W-1:0]  occ_new;
    logic              occ_we;
    logic [VA_W-1:0]   occ_waddr;
    logic [OCC_W-1:0]  occ_wdata;

    assign out_free    = !r_o_valid || i_ready;
    assign o_pop_ready = (r_state == S_IDLE) && ((i_pop_entry.op != OP_BAD) || out_free);
    assign take        = i_pop_valid && o_pop_ready;
    assign load_take   = take && (i_pop_entry.op == OP_LOAD);
    assign o_init_done = r_init_done;
    assign out_load    = (take && (i_pop_entry.op == OP_BAD))
                      || ((r_state == S_FIN) && out_free);

    assign mv_left_up = (r_win_left < r_left);
    assign mv_left_dn = (r_win_left > r_left);
    assign mv_end_up  = (r_win_end < r_stop);
    assign mv_end_dn  = (r_win_end > r_stop);
    assign move_any   = mv_left_up || mv_left_dn || mv_end_up || mv_end_dn;

    // The left edge is settled first, then the end edge, one element per step.
    always_comb begin
        mv_add     = 1'b0;
        mv_addr    = r_win_left;
        n_win_left = r_win_left;
        n_win_end  = r_win_end;
        if (mv_left_up) begin
            mv_add     = 1'b0;
            mv_addr    = r_win_left;
            n_win_left = r_win_left + EDGE_W'(1);
        end else if (mv_left_dn) begin
            mv_add     = 1'b1;
            mv_addr    = r_win_left - EDGE_W'(1);
            n_win_left = r_win_left - EDGE_W'(1);
        end else if (mv_end_up) begin
            mv_add    = 1'b1;
            mv_addr   = r_win_end;
            n_win_end = r_win_end + EDGE_W'(1);
        end else if (mv_end_dn) begin
            mv_add    = 1'b0;
            mv_addr   = r_win_end - EDGE_W'(1);
            n_win_end = r_win_end - EDGE_W'(1);
        end
    end

    assign occ_new   = r_add ? (r_occ_q + OCC_W'(1)) : (r_occ_q - OCC_W'(1));
    assign occ_we    = (r_state == S_WIPE) || (r_state == S_UPD);
    assign occ_waddr = (r_state == S_WIPE) ? r_wipe_addr : r_vaddr;
    assign occ_wdata = (r_state == S_WIPE) ? '0 : occ_new;

    always_ff @(posedge i_clk) begin
        if (load_take) begin
            r_elements[EA_W'(i_pop_entry.idx_a)] <= i_pop_entry.idx_b;
        end
        if ((r_state == S_MOVE) && move_any) begin
            r_elem_q <= r_elements[mv_addr[EA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            r_occ[occ_waddr] <= occ_wdata;
        end
        if (r_state == S_RDE) begin
            r_occ_q <= r_occ[VA_W'(r_elem_q)];
            r_vaddr <= VA_W'(r_elem_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_init_done <= 1'b0;
            r_wipe_addr <= '0;
            r_win_left  <= '0;
            r_win_end   <= '0;
            r_running   <= '0;
            r_left      <= '0;
            r_stop      <= '0;
            r_tag       <= '0;
            r_add       <= 1'b0;
            r_o_count   <= '0;
            r_o_tag     <= '0;
            r_o_status  <= 1'b0;
        end else begin
            unique case (r_state)
                S_WIPE: begin
                    r_wipe_addr <= r_wipe_addr + VA_W'(1);
                    if (r_wipe_addr == VA_W'(VALUE_SLOTS - 1)) begin
                        r_state     <= S_IDLE;
                        r_init_done <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (take) begin
                        case (i_pop_entry.op)
                            OP_QUERY: begin
                                r_left  <= EDGE_W'(i_pop_entry.idx_a);
                                r_stop  <= EDGE_W'(i_pop_entry.idx_b) + EDGE_W'(1);
                                r_tag   <= i_pop_entry.tag;
                                r_state <= S_MOVE;
                            end
                            OP_BAD: begin
                                r_o_count  <= '0;
                                r_o_tag    <= i_pop_entry.tag;
                                r_o_status <= 1'b1;
                            end
                            OP_CLEAR: begin
                                r_win_left  <= '0;
                                r_win_end   <= '0;
                                r_running   <= '0;
                                r_wipe_addr <= '0;
                                r_state     <= S_WIPE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MOVE: begin
                    if (move_any) begin
                        r_add      <= mv_add;
                        r_win_left <= n_win_left;
                        r_win_end  <= n_win_end;
                        r_state    <= S_RDE;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RDE: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_add && (occ_new == OCC_W'(1))) begin
                        r_running <= r_running + CNT_W'(1);
                    end else if (!r_add && (occ_new == '0)) begin
                        r_running <= r_running - CNT_W'(1);
                    end
                    r_state <= S_MOVE;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_count  <= r_running;
                        r_o_tag    <= r_tag;
                        r_o_status <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_o_valid;
    assign o_distinct_count = r_o_count;
    assign o_answer_tag     = r_o_tag;
    assign o_status         = r_o_status;

endmodule

// ===== sv/range_distinct_count_window.sv =====
// Distinct values in an index range, counted over a sliding window.
// Input channel (i_valid/o_ready) takes one command per item: load an element,
// query a range, or start a new case, which empties the histogram and window.
// Output channel (o_valid/i_ready) gives one answer per query with its tag;
// a bad range answers status 1 and a count of zero, leaving the window alone.
// The element count is written on the cfg channel (always ready); the user
// must write it only while idle, since the block itself does not enforce it.
// A query moves either window edge one element per step; each move reads the
// element memory (S_MOVE), then the histogram memory (S_RDE), then writes
// the histogram back (S_UPD). Loads are written as the back end takes them;
// a new case sweeps the histogram memory to zero, as after reset.
// A two-entry queue sits between the command front end and the back end.
// After reset the histogram memory is swept to zero, during which o_ready
// stays low. If the receiver stalls, the answer is held in the output
// register; loads and new cases still proceed behind it and the next query
// waits only when it has an answer ready to deliver.
module range_distinct_count_window
    import rdcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CMD_W-1:0] i_command,
    input  logic [IDX_W-1:0] i_position,
    input  logic [VAL_W-1:0] i_value,
    input  logic [IDX_W-1:0] i_left,
    input  logic [IDX_W-1:0] i_right,
    input  logic [TAG_W-1:0] i_tag,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CNT_W-1:0] o_distinct_count,
    output logic [TAG_W-1:0] o_answer_tag,
    output logic             o_status
);

    logic   push_valid;
    t_entry push_entry;
    logic   push_ready;
    logic   pop_valid;
    t_entry pop_entry;
    logic   pop_ready;
    logic   init_done;

    rdcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_left       (i_left),
        .i_right      (i_right),
        .i_tag        (i_tag),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_init_done  (init_done),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    rdcw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_entry  (pop_entry),
        .i_pop_ready  (pop_ready)
    );

    rdcw_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pop_valid      (pop_valid),
        .i_pop_entry      (pop_entry),
        .o_pop_ready      (pop_ready),
        .o_init_done      (init_done),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_distinct_count (o_distinct_count),
        .o_answer_tag     (o_answer_tag),
        .o_status         (o_status)
    );

endmodule

// ===== sv/rdcw_checker.sv =====
`include "range_distinct_count_window_assert.svh"

module rdcw_checker
    import rdcw_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic [CMD_W-1:0] i_command,
    input logic             o_valid,
    input logic             i_ready,
    input logic [CNT_W-1:0] o_distinct_count,
    input logic [TAG_W-1:0] o_answer_tag,
    input logic             o_status
);

    // Queries accepted whose answers have not yet been taken.
    logic [3:0] r_pending;
    logic       query_in;
    logic       answer_out;

    assign query_in   = i_valid && o_ready && (i_command == CMD_QUERY);
    assign answer_out = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 4'(query_in) - 4'(answer_out);
        end
    end

    `RDCW_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)
    `RDCW_ASSERT_NEXT(a_tag_hold, o_valid && !i_ready, $stable(o_answer_tag))
    `RDCW_ASSERT_IMPL(a_bad_zero, o_valid && o_status, o_distinct_count == '0)
    `RDCW_ASSERT_IMPL(a_no_orphan, o_valid, r_pending != '0)

endmodule

bind range_distinct_count_window rdcw_checker u_checker (.*);
